>>> hw/rtl/mkd_pkg.sv
// Shared types, constants and the letter lookup for the Morse key decoder.
// No dependencies; imported by mkd_decode, morse_key_decoder and both bench files.
package mkd_pkg;

    localparam int MAX_SYMBOLS = 4;
    localparam int WORD_LENGTH = 4;

    // Longest pattern that can map to a letter
    localparam int MAX_CODE_LEN = 4;

    localparam int COUNT_W = 3;
    localparam int WORD_W  = $clog2(WORD_LENGTH + 1);
    localparam int TICK_W  = 8;
    localparam int TIME_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W  = 3;
    localparam int LETTER_W = 5;
    localparam int TABLE_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DOT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd3;

    localparam logic [TICK_W-1:0] DOT_LIMIT_RST  = 8'd5;
    localparam logic [TICK_W-1:0] DASH_LIMIT_RST = 8'd14;
    localparam logic [TICK_W-1:0] GAP_LIMIT_RST  = 8'd8;
    localparam logic [TIME_W-1:0] TIMEOUT_RST    = 16'd80;

    typedef enum logic [KIND_W-1:0] {
        EV_LETTER    = 3'd0,
        EV_INVALID   = 3'd1,
        EV_TOO_LONG  = 3'd2,
        EV_TOO_MANY  = 3'd3,
        EV_TIMEOUT   = 3'd4
    } t_event;

    typedef struct packed {
        logic                found;
        logic [LETTER_W-1:0] letter;
    } t_decode;

    // Indexed by (1 << length) + pattern, dash = 1, first symbol in the MSB
    function automatic t_decode letter_lookup(input logic [TABLE_W-1:0] idx);
        t_decode d;
        d.found = 1'b1;
        case (idx)
            5'd2:    d.letter = 5'd4;
            5'd3:    d.letter = 5'd19;
            5'd4:    d.letter = 5'd8;
            5'd5:    d.letter = 5'd0;
            5'd6:    d.letter = 5'd13;
            5'd7:    d.letter = 5'd12;
            5'd8:    d.letter = 5'd18;
            5'd9:    d.letter = 5'd20;
            5'd10:   d.letter = 5'd17;
            5'd11:   d.letter = 5'd22;
            5'd12:   d.letter = 5'd3;
            5'd13:   d.letter = 5'd10;
            5'd14:   d.letter = 5'd6;
            5'd15:   d.letter = 5'd14;
            5'd16:   d.letter = 5'd7;
            5'd17:   d.letter = 5'd21;
            5'd18:   d.letter = 5'd5;
            5'd20:   d.letter = 5'd11;
            5'd22:   d.letter = 5'd15;
            5'd23:   d.letter = 5'd9;
            5'd24:   d.letter = 5'd1;
            5'd25:   d.letter = 5'd23;
            5'd26:   d.letter = 5'd2;
            5'd27:   d.letter = 5'd24;
            5'd28:   d.letter = 5'd25;
            5'd29:   d.letter = 5'd16;
            default: begin
                d.found  = 1'b0;
                d.letter = '0;
            end
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/morse_key_decoder.sv
// Morse key decoder top level: press/gap timing, symbol store, result register.
// Depends on mkd_pkg and mkd_decode.
// A result item appears in the cycle after the key level item that causes it is accepted.
// Throughput: one key level item per cycle; a pending result only stalls input
// while it is not being taken.
// Reset (synchronous, active low): counters, store and word count clear,
// limits return to their defaults, output empty.
module morse_key_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mkd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mkd_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_key_level,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mkd_pkg::KIND_W-1:0]       o_event_kind,
    output logic [mkd_pkg::LETTER_W-1:0]     o_letter_index,
    output logic                             o_word_end
);
    import mkd_pkg::*;

    // Configuration
    logic [TICK_W-1:0] r_dot_limit, r_dash_limit, r_gap_limit;
    logic [TIME_W-1:0] r_timeout;

    // Timing and symbol state
    logic [TICK_W-1:0]      r_press, n_press;
    logic [TICK_W-1:0]      r_gap, n_gap;
    logic [TIME_W-1:0]      r_elapsed, n_elapsed;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic [MAX_SYMBOLS-1:0] r_dash, n_dash;   // 1 = dash, only first r_count valid
    logic [WORD_W-1:0]      r_words, n_words;

    // Result register
    logic                r_out_valid;
    t_event              r_kind, n_kind;
    logic [LETTER_W-1:0] r_letter, n_letter;
    logic                r_wend, n_wend;
    logic                n_event;

    logic    accept;
    logic    clear;
    t_decode dec;

    // Store after this tick's symbol, before any clear
    logic                   sym_err;
    t_event                 sym_kind;
    logic [COUNT_W-1:0]     app_count;
    logic [MAX_SYMBOLS-1:0] app_dash;

    // Take a new item whenever the result slot is empty or emptying
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Decode the store as it stands after this tick's symbol is appended
    mkd_decode u_decode (
        .i_count  (app_count),
        .i_dash   (app_dash),
        .o_result (dec)
    );

    // First idle tick after a press: classify it and append the symbol
    always_comb begin
        app_count = r_count;
        app_dash  = r_dash;
        sym_err   = 1'b0;
        sym_kind  = EV_TOO_LONG;
        if (!i_key_level && r_press != '0) begin
            if (r_press >= r_dash_limit && r_press >= r_dot_limit) begin
                sym_err = 1'b1;
            end else if (r_count >= COUNT_W'(MAX_SYMBOLS)) begin
                // store full: drop the symbol
                sym_err  = 1'b1;
                sym_kind = EV_TOO_MANY;
            end else begin
                for (int i = 0; i < MAX_SYMBOLS; i++) begin
                    if (COUNT_W'(i) == r_count) begin
                        app_dash[i] = (r_press >= r_dot_limit);
                    end
                end
                app_count = r_count + COUNT_W'(1);
            end
        end
    end

    always_comb begin
        n_press   = r_press;
        n_gap     = r_gap;
        n_count   = app_count;
        n_dash    = app_dash;
        n_words   = r_words;
        n_event   = 1'b0;
        n_kind    = EV_LETTER;
        n_letter  = '0;
        n_wend    = 1'b0;
        clear     = 1'b0;
        n_elapsed = (r_elapsed != '1) ? r_elapsed + TIME_W'(1) : r_elapsed;

        if (i_key_level) begin
            // Key held: extend the press, restart the gap
            if (r_press != '1) begin
                n_press = r_press + TICK_W'(1);
            end
            n_gap = '0;
        end else begin
            if (r_gap != '1) begin
                n_gap = r_gap + TICK_W'(1);
            end
            // Press just ended: raise its error, if any, and restart the count
            if (r_press != '0) begin
                if (sym_err) begin
                    n_event = 1'b1;
                    n_kind  = sym_kind;
                    clear   = 1'b1;
                end
                n_press = '0;
            end
            // Long gap with symbols stored: end the letter
            if (!n_event && n_gap > r_gap_limit && n_count != '0) begin
                n_event = 1'b1;
                clear   = 1'b1;
                if (dec.found) begin
                    n_kind   = EV_LETTER;
                    n_letter = dec.letter;
                    if (r_words + WORD_W'(1) >= WORD_W'(WORD_LENGTH)) begin
                        n_wend  = 1'b1;
                        n_words = '0;
                    end else begin
                        n_words = r_words + WORD_W'(1);
                    end
                end else begin
                    n_kind = EV_INVALID;
                end
            end
        end

        // Letter timer runs regardless of the key
        if (!n_event && n_elapsed >= r_timeout) begin
            n_event = 1'b1;
            n_kind  = EV_TIMEOUT;
            clear   = 1'b1;
        end

        if (clear) begin
            n_count   = '0;
            n_dash    = '0;
            n_elapsed = '0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_limit  <= DOT_LIMIT_RST;
            r_dash_limit <= DASH_LIMIT_RST;
            r_gap_limit  <= GAP_LIMIT_RST;
            r_timeout    <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DOT_LIMIT:  r_dot_limit  <= i_cfg_data[TICK_W-1:0];
                CFG_DASH_LIMIT: r_dash_limit <= i_cfg_data[TICK_W-1:0];
                CFG_GAP_LIMIT:  r_gap_limit  <= i_cfg_data[TICK_W-1:0];
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    // Advance state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press   <= '0;
            r_gap     <= '0;
            r_elapsed <= '0;
            r_count   <= '0;
            r_dash    <= '0;
            r_words   <= '0;
        end else if (accept) begin
            r_press   <= n_press;
            r_gap     <= n_gap;
            r_elapsed <= n_elapsed;
            r_count   <= n_count;
            r_dash    <= n_dash;
            r_words   <= n_words;
        end
    end

    // Result slot: load on an item with an event, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_event;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_event) begin
            r_kind   <= n_kind;
            r_letter <= n_letter;
            r_wend   <= n_wend;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_letter_index = r_letter;
    assign o_word_end     = r_wend;

    // A stalled result must block new input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while result stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(MAX_SYMBOLS))
        else $error("symbol count beyond store depth");

    a_wend_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_wend) |-> (r_kind == EV_LETTER))
        else $error("word end flagged on an error");

    a_key_clears_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_key_level) |=> (r_gap == '0))
        else $error("gap not restarted by key press");

    a_event_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_event) |=> (r_elapsed == '0 && r_count == '0))
        else $error("event left store or timer running");

endmodule

>>> hw/rtl/mkd_decode.sv
// Pattern decoder: turns the stored dot/dash sequence into a letter.
// Depends on mkd_pkg (letter_lookup, t_decode).
module mkd_decode (
    input  logic [mkd_pkg::COUNT_W-1:0]     i_count,
    input  logic [mkd_pkg::MAX_SYMBOLS-1:0] i_dash,
    output mkd_pkg::t_decode                o_result
);
    import mkd_pkg::*;

    logic [TABLE_W-1:0] pat;
    logic [TABLE_W-1:0] idx;
    t_decode            hit;

    always_comb begin
        pat = '0;
        for (int i = 0; i < MAX_CODE_LEN; i++) begin
            if (COUNT_W'(i) < i_count) begin
                pat = {pat[TABLE_W-2:0], i_dash[i]};
            end
        end
        idx = pat | (TABLE_W'(1) << i_count);
        hit = letter_lookup(idx);
        // empty or over-long patterns are never letters
        if (i_count == '0 || i_count > COUNT_W'(MAX_CODE_LEN)) begin
            o_result = '0;
        end else begin
            o_result = hit;
        end
    end

endmodule

>>> tb/tb_mkd_scoreboard_pkg.sv
// Scoreboard for the Morse key decoder bench: tick-by-tick prediction of decoded
// events and the queue they wait in until the block delivers them.
// Depends on mkd_pkg for widths, limits, register indexes and event codes.
package tb_mkd_scoreboard_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import mkd_pkg::*;

    typedef enum logic [1:0] {
        SYM_EMPTY = 2'd0,
        SYM_DOT   = 2'd1,
        SYM_DASH  = 2'd2
    } t_symbol;

    localparam byte unsigned NO_LETTER = 8'hFF;

    typedef struct {
        t_event              kind;
        logic [LETTER_W-1:0] letter;
        logic                word_end;
    } t_key_event;

    class key_event_scoreboard;
        logic [TICK_W-1:0]  dot_limit;
        logic [TICK_W-1:0]  dash_limit;
        logic [TICK_W-1:0]  gap_limit;
        logic [TIME_W-1:0]  letter_timeout;

        logic [TICK_W-1:0]  held_for;
        logic [TICK_W-1:0]  idle_for;
        t_symbol            symbols [MAX_SYMBOLS];
        logic [COUNT_W-1:0] n_symbols;
        logic [TIME_W-1:0]  since_letter;
        logic [WORD_W-1:0]  word_fill;

        // code word = leading one, then one bit per symbol (dash = 1)
        byte unsigned       letter_at [32];
        t_key_event         events_due [$];

        int keys_seen;
        int kind_tally [5];
        int word_ends;
        int errors;

        function new();
            string morse [26] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
                                  "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
                                  "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
                                  "-.--", "--.."};
            logic [4:0] code;
            for (int i = 0; i < 32; i++)
                letter_at[i] = NO_LETTER;
            for (int i = 0; i < 26; i++) begin
                code = 5'd1;
                for (int j = 0; j < morse[i].len(); j++)
                    code = {code[3:0], morse[i].getc(j) == "-"};
                letter_at[code] = byte'(i);
            end
            dot_limit      = DOT_LIMIT_RST;
            dash_limit     = DASH_LIMIT_RST;
            gap_limit      = GAP_LIMIT_RST;
            letter_timeout = TIMEOUT_RST;
            held_for       = '0;
            idle_for       = '0;
            word_fill      = '0;
            end_letter();
            keys_seen = 0;
            word_ends = 0;
            errors    = 0;
            foreach (kind_tally[k])
                kind_tally[k] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_DOT_LIMIT:  dot_limit      = value[TICK_W-1:0];
                CFG_DASH_LIMIT: dash_limit     = value[TICK_W-1:0];
                CFG_GAP_LIMIT:  gap_limit      = value[TICK_W-1:0];
                CFG_TIMEOUT:    letter_timeout = value[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        function void end_letter();
            foreach (symbols[s])
                symbols[s] = SYM_EMPTY;
            n_symbols    = '0;
            since_letter = '0;
        endfunction

        // Advance one tick and queue the event it raises, if any.
        function void note_key(logic key);
            t_key_event ev;
            t_symbol    sym;
            logic [4:0] code;
            bit         fired;
            fired       = 1'b0;
            ev.kind     = EV_LETTER;
            ev.letter   = '0;
            ev.word_end = 1'b0;
            keys_seen++;
            if (since_letter != '1)
                since_letter++;
            if (key) begin
                if (held_for != '1)
                    held_for++;
                idle_for = '0;
            end else begin
                if (idle_for != '1)
                    idle_for++;
                if (held_for != 0) begin
                    if (held_for < dot_limit)
                        sym = SYM_DOT;
                    else if (held_for < dash_limit)
                        sym = SYM_DASH;
                    else
                        sym = SYM_EMPTY;
                    if (sym == SYM_EMPTY) begin
                        fired   = 1'b1;
                        ev.kind = EV_TOO_LONG;
                    end else if (n_symbols >= MAX_SYMBOLS) begin
                        fired   = 1'b1;
                        ev.kind = EV_TOO_MANY;
                    end else begin
                        symbols[n_symbols] = sym;
                        n_symbols++;
                    end
                    held_for = '0;
                    if (fired)
                        end_letter();
                end
                if (!fired && idle_for > gap_limit && n_symbols != 0) begin
                    code = 5'd1;
                    for (int i = 0; i < n_symbols; i++)
                        code = {code[3:0], symbols[i] == SYM_DASH};
                    fired = 1'b1;
                    if (letter_at[code] == NO_LETTER) begin
                        ev.kind = EV_INVALID;
                    end else begin
                        ev.letter = letter_at[code][LETTER_W-1:0];
                        word_fill++;
                        if (word_fill >= WORD_LENGTH) begin
                            ev.word_end = 1'b1;
                            word_fill   = '0;
                        end
                    end
                    end_letter();
                end
            end
            if (!fired && since_letter >= letter_timeout) begin
                fired   = 1'b1;
                ev.kind = EV_TIMEOUT;
                end_letter();
            end
            if (fired)
                events_due.push_back(ev);
        endfunction

        function void check_event(logic [KIND_W-1:0] kind, logic [LETTER_W-1:0] letter,
                                  logic word_end);
            t_key_event due;
            if (events_due.size() == 0) begin
                $display("%0t: unexpected event: kind %0d letter %0d word_end %0d",
                         $time, kind, letter, word_end);
                errors++;
                return;
            end
            due = events_due.pop_front();
            kind_tally[due.kind]++;
            if (due.word_end)
                word_ends++;
            if (kind !== due.kind) begin
                $display("%0t: event kind expected %0d, got %0d", $time, due.kind, kind);
                errors++;
            end
            if (letter !== due.letter) begin
                $display("%0t: letter index expected %0d, got %0d", $time, due.letter, letter);
                errors++;
            end
            if (word_end !== due.word_end) begin
                $display("%0t: word end expected %0d, got %0d", $time, due.word_end, word_end);
                errors++;
            end
        endfunction

        function int pending();
            return events_due.size();
        endfunction

        function void report_leftover();
            if (events_due.size() != 0) begin
                $display("%0t: %0d expected events never delivered", $time, events_due.size());
                errors += events_due.size();
            end
        endfunction
    endclass

endpackage

>>> tb/tb_morse_key_decoder.sv
// Top-level bench for morse_key_decoder: drives key levels and limit writes,
// checks every decoded event against the scoreboard's prediction.
// Depends on mkd_pkg, tb_mkd_scoreboard_pkg and the decoder RTL.
module tb_morse_key_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import mkd_pkg::*;
    import tb_mkd_scoreboard_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_key_level;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [KIND_W-1:0]   o_event_kind;
    logic [LETTER_W-1:0] o_letter_index;
    logic                o_word_end;

    key_event_scoreboard board;

    // idle-gap switches for sender and receiver, and the hold-off request count
    bit tx_gaps;
    bit rx_gaps;
    int stall_requests = 0;
    int stall_served   = 0;
    int keys_sent      = 0;

    // limits currently programmed, used to shape the key timing
    int cur_dot;
    int cur_dash;
    int cur_gap;
    int cur_tmo;

    morse_key_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_key_level    (i_key_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_kind   (o_event_kind),
        .o_letter_index (o_letter_index),
        .o_word_end     (o_word_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block wedges or an event never turns up.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: take events with random stalls; on request, hold off for a
    // long stretch so the pending event backs up into the key input.
    initial begin : receiver
        int hold;
        hold        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_served != stall_requests) begin
                stall_served = stall_requests;
                hold         = 90;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if (rx_gaps && $urandom_range(99, 0) < 14) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Check every event the block hands over, in order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_event(o_event_kind, o_letter_index, o_word_end);
    end

    // Offer one key level and hold it until the block takes it. Entered and
    // left at a falling edge.
    task automatic send_key(input logic level);
        if (tx_gaps && $urandom_range(99, 0) < 14) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_key_level <= level;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        board.note_key(level);
        keys_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_run(input logic level, input int n);
        repeat (n) send_key(level);
    endtask

    task automatic send_pattern(input string keys);
        for (int i = 0; i < keys.len(); i++)
            send_key(keys.getc(i) == "1");
    endtask

    // Pick a length in [lo, hi]: mostly short, with the two bounds hit often.
    function automatic int pick_len(input int lo, input int hi);
        int r;
        r = $urandom_range(7, 0);
        if (r == 0)
            return hi;
        if (r == 1)
            return lo;
        if (hi > lo + 12)
            hi = lo + 12;
        return $urandom_range(hi, lo);
    endfunction

    // Press length for the wanted symbol; SYM_EMPTY asks for an over-long press.
    // Fall back to whatever the current limits still allow.
    function automatic int press_len(input t_symbol want);
        int long_lo;
        long_lo = (cur_dot > cur_dash) ? cur_dot : cur_dash;
        if (want == SYM_DOT && cur_dot > 1)
            return pick_len(1, cur_dot - 1);
        if (want != SYM_EMPTY && cur_dash > cur_dot)
            return pick_len(cur_dot, cur_dash - 1);
        if (want != SYM_EMPTY && cur_dot > 1)
            return pick_len(1, cur_dot - 1);
        return pick_len(long_lo, long_lo + 3);
    endfunction

    // One letter: a few symbols with short gaps, then a gap that closes it.
    // Now and then add a fifth symbol or an over-long press to break it.
    task automatic send_letter();
        int      n_sym;
        int      r;
        t_symbol want;
        r     = $urandom_range(99, 0);
        n_sym = (r < 10) ? MAX_SYMBOLS + 1 : $urandom_range(MAX_SYMBOLS, 1);
        for (int s = 0; s < n_sym; s++) begin
            r = $urandom_range(99, 0);
            if (r < 4)
                want = SYM_EMPTY;
            else if (r < 52)
                want = SYM_DOT;
            else
                want = SYM_DASH;
            send_run(1'b1, press_len(want));
            if (s < n_sym - 1)
                send_run(1'b0, pick_len(1, cur_gap));
        end
        send_run(1'b0, cur_gap + 1 + $urandom_range(2, 0));
    endtask

    // Mostly well-formed letters; the rest is key noise and long silences
    // that let the letter timer run out.
    task automatic random_phase(input int n_keys);
        int goal;
        int r;
        goal = keys_sent + n_keys;
        while (keys_sent < goal) begin
            r = $urandom_range(99, 0);
            if (r < 80)
                send_letter();
            else if (r < 92)
                repeat ($urandom_range(6, 1)) send_key(1'($urandom_range(1, 0)));
            else
                send_run(1'b0, pick_len(1, (cur_tmo < 300) ? cur_tmo + 2 : 300));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        @(negedge i_clk);
        board.set_reg(idx, value[CFG_W-1:0]);
    endtask

    // Program all four limits; only called while the block is idle.
    task automatic set_limits(input int dot, input int dash, input int gap, input int tmo);
        write_reg(CFG_DOT_LIMIT, dot);
        write_reg(CFG_DASH_LIMIT, dash);
        write_reg(CFG_GAP_LIMIT, gap);
        write_reg(CFG_TIMEOUT, tmo);
        i_cfg_we <= 1'b0;
        cur_dot  = dot;
        cur_dash = dash;
        cur_gap  = gap;
        cur_tmo  = tmo;
    endtask

    // Drop valid and wait for every expected event, then let the last key level
    // fully pass through.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int wait_cycles;
        board       = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_key_level = 1'b0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        cur_dot     = DOT_LIMIT_RST;
        cur_dash    = DASH_LIMIT_RST;
        cur_gap     = GAP_LIMIT_RST;
        cur_tmo     = TIMEOUT_RST;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: one-tick dot, two-tick dash, two idle ticks close a letter.
        set_limits(2, 3, 1, 20);
        send_pattern("101100");         // A, lowest letter index
        send_pattern("11011010100");    // Z, highest letter index
        send_pattern("1110");           // press too long
        send_pattern("10101010100");    // fifth dot overflows, then the gap finds nothing
        send_pattern("10110101100");    // dot-dash-dot-dash is no letter
        drain();

        // Timeout on every tick; hold the receiver off so input stalls.
        set_limits(2, 3, 1, 1);
        stall_requests++;
        random_phase(60);
        drain();

        // No dots at all, longest presses, shortest gap, timer out of reach.
        set_limits(1, 255, 1, 65535);
        send_run(1'b1, 258);
        send_run(1'b0, 2);
        random_phase(40);
        drain();

        // Long stretch with neither side idling.
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        set_limits(5, 14, 8, 2000);
        random_phase(150);
        drain();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // Random limits, with a pause mid-phase until everything has come out.
        repeat (2) begin
            set_limits($urandom_range(12, 1), $urandom_range(20, 1), $urandom_range(10, 1),
                       $urandom_range(400, 1));
            random_phase(60);
            drain();
            random_phase(60);
            drain();
        end

        // Widest gap: a letter can never close by silence, only time out or end on an error.
        set_limits(3, 6, 255, 300);
        random_phase(100);
        drain();

        // Back to the reset limits.
        set_limits(DOT_LIMIT_RST, DASH_LIMIT_RST, GAP_LIMIT_RST, TIMEOUT_RST);
        random_phase(80);

        i_in_valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 2000 && board.pending() != 0; wait_cycles++)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        board.report_leftover();

        $display("Covered %0d key levels under eight limit settings: %0d letters (%0d word ends),",
                 board.keys_seen, board.kind_tally[EV_LETTER], board.word_ends);
        $display("%0d invalid patterns, %0d over-long presses, %0d overflows, %0d timeouts.",
                 board.kind_tally[EV_INVALID], board.kind_tally[EV_TOO_LONG],
                 board.kind_tally[EV_TOO_MANY], board.kind_tally[EV_TIMEOUT]);
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_decode.sv
hw/rtl/morse_key_decoder.sv
tb/tb_mkd_scoreboard_pkg.sv
tb/tb_morse_key_decoder.sv
